// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising edge of clk outside reset.
`define MGPA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mgpa assertion failed");
// Condition that must never hold at a rising edge of clk outside reset.
`define MGPA_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("mgpa forbidden condition seen");
`else
`define MGPA_ASSERT(label, prop)
`define MGPA_NEVER(label, cond)
`endif
`endif

// File: hdl/mgpa_pkg.sv
// Package with the types and constants of the motion gated pixel accumulator.
package mgpa_pkg;

    localparam int IMG_WIDTH  = 640;
    localparam int IMG_HEIGHT = 480;
    localparam int FRAME_SIZE = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W     = $clog2(FRAME_SIZE);

    localparam int IDX_W      = 19;
    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 9;
    localparam int FRAC_W     = 8;
    localparam int TOT_W      = PIX_W + GAIN_W + 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLICKER_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_GAIN   = 2'd3;

    localparam logic [GAIN_W-1:0] RISE_GAIN_RESET = 9'd128;
    localparam logic [GAIN_W-1:0] FALL_GAIN_RESET = 9'd20;

    localparam logic [0:0] KIND_LOAD    = 1'b0;
    localparam logic [0:0] KIND_PROCESS = 1'b1;

    localparam logic signed [TOT_W-1:0] TOTAL_MAX = TOT_W'(255 * 256);
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_HOLD,
        OP_APPROACH
    } op_t;

    typedef struct packed {
        logic [0:0]       kind;
        logic [IDX_W-1:0] pixel_index;
        logic [PIX_W-1:0] source_pixel;
        logic [PIX_W-1:0] background_pixel;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [PIX_W-1:0] out_pixel;
        logic             was_updated;
    } out_item_t;

    typedef struct packed {
        op_t              op;
        logic             in_range;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] bg;
    } task_t;

    typedef struct packed {
        logic [PIX_W-1:0]  move_thr;
        logic [PIX_W-1:0]  flicker_thr;
        logic [GAIN_W-1:0] rise_gain;
        logic [GAIN_W-1:0] fall_gain;
    } cfg_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } q_stat_t;

endpackage

// File: hdl/mgpa_if.sv
// Valid/ready channel interfaces for the input items and the result items.
interface mgpa_in_if;
    import mgpa_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mgpa_out_if;
    import mgpa_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/motion_gated_pixel_accumulator_unit.sv
// Top level of the motion gated pixel accumulator: config registers and wiring.
//
// Usage: pix_in carries one item per transaction (kind, pixel_index,
// source_pixel, background_pixel); pix_out returns exactly one result per
// item (out_index, out_pixel, was_updated) in the same order. A load item
// writes background_pixel into the accumulator entry; a process item moves
// the entry toward source_pixel when the motion gate passes.
// The configuration port writes thresholds and gains by index on any edge
// with cfg_write_en high; write it only while no item is in flight.
// A result reaches pix_out through the queue entry, the back-end task register
// and the result register. Throughput is one item per cycle while pix_out.ready
// is high, set by the single read and single write port of the accumulator memory.
// Reset clears the queue and the valid flags and loads the register reset
// values; the accumulator memory itself is not cleared, so every entry must
// be loaded before it is processed. When the receiver holds pix_out.ready
// low the result register holds, the back end and the four-entry queue
// fill, and pix_in.ready drops once the queue is full.
`include "assert_macros.svh"

module motion_gated_pixel_accumulator_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mgpa_in_if.sink                              pix_in,
    mgpa_out_if.source                           pix_out,
    input  logic                                 cfg_write_en,
    input  logic [mgpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mgpa_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mgpa_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    q_stat_t q_stat;
    task_t   push_task;
    task_t   head;
    logic    push;
    logic    pop;
    logic    rise_gain_wr;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MOVE_THR:    cfg_next.move_thr    = cfg_data[PIX_W-1:0];
                CFG_FLICKER_THR: cfg_next.flicker_thr = cfg_data[PIX_W-1:0];
                CFG_RISE_GAIN:   cfg_next.rise_gain   = cfg_data[GAIN_W-1:0];
                CFG_FALL_GAIN:   cfg_next.fall_gain   = cfg_data[GAIN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.move_thr    <= '0;
            cfg_reg.flicker_thr <= '0;
            cfg_reg.rise_gain   <= RISE_GAIN_RESET;
            cfg_reg.fall_gain   <= FALL_GAIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mgpa_front u_front (
        .pix_in    (pix_in),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_task (push_task)
    );

    mgpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_task (push_task),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    mgpa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .q_stat  (q_stat),
        .pop     (pop),
        .pix_out (pix_out)
    );

    assign rise_gain_wr = cfg_write_en && (cfg_index == CFG_RISE_GAIN);

    `MGPA_NEVER(a_pop_empty, pop && q_stat.empty)
    `MGPA_NEVER(a_queue_over, q_stat.count > QCNT_W'(QUEUE_DEPTH))
    `MGPA_ASSERT(a_rise_gain_write, rise_gain_wr |=> (cfg_reg.rise_gain == $past(cfg_data)))
    `MGPA_ASSERT(a_count_step, (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))

endmodule

// File: hdl/mgpa_front.sv
// Front end: takes input transactions and classifies them into queue tasks.
module mgpa_front (
    mgpa_in_if.sink              pix_in,
    input  mgpa_pkg::cfg_t       cfg,
    input  mgpa_pkg::q_stat_t    q_stat,
    output logic                 push,
    output mgpa_pkg::task_t      push_task
);
    import mgpa_pkg::*;

    logic [PIX_W-1:0] diff;
    logic             gate;

    assign pix_in.ready = !q_stat.full;
    assign push         = pix_in.valid && !q_stat.full;

    always_comb
    begin
        if (pix_in.data.source_pixel > pix_in.data.background_pixel)
        begin
            diff = pix_in.data.source_pixel - pix_in.data.background_pixel;
        end
        else
        begin
            diff = pix_in.data.background_pixel - pix_in.data.source_pixel;
        end
        gate = (diff > cfg.move_thr) && (pix_in.data.source_pixel > cfg.flicker_thr);
    end

    always_comb
    begin
        push_task.idx      = pix_in.data.pixel_index;
        push_task.src      = pix_in.data.source_pixel;
        push_task.bg       = pix_in.data.background_pixel;
        push_task.in_range = ({1'b0, pix_in.data.pixel_index} < (IDX_W + 1)'(FRAME_SIZE));
        if (pix_in.data.kind == KIND_LOAD)
        begin
            push_task.op = OP_LOAD;
        end
        else if (gate)
        begin
            push_task.op = OP_APPROACH;
        end
        else
        begin
            push_task.op = OP_HOLD;
        end
    end

endmodule

// File: hdl/mgpa_queue.sv
// Short task queue between the front end and the back end.
module mgpa_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mgpa_pkg::task_t      push_task,
    input  logic                 pop,
    output mgpa_pkg::task_t      head,
    output mgpa_pkg::q_stat_t    q_stat
);
    import mgpa_pkg::*;

    task_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.count = count_reg;
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

// File: hdl/mgpa_back.sv
// Back end: reads the accumulator, applies the update and drives the results.
module mgpa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mgpa_pkg::cfg_t       cfg,
    input  mgpa_pkg::task_t      head,
    input  mgpa_pkg::q_stat_t    q_stat,
    output logic                 pop,
    mgpa_out_if.source           pix_out
);
    import mgpa_pkg::*;

    logic [PIX_W-1:0] frame_mem [FRAME_SIZE];

    logic             b_valid_reg;
    logic             b_valid_next;
    task_t            b_task_reg;
    logic [PIX_W-1:0] rd_data_reg;
    logic             fwd_hit_reg;
    logic             fwd_hit_next;
    logic [PIX_W-1:0] fwd_data_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_item_reg;

    logic                     b_leave;
    logic [PIX_W-1:0]         acc;
    logic signed [PIX_W:0]    delta;
    logic signed [GAIN_W:0]   gain;
    logic signed [TOT_W-1:0]  product;
    logic signed [TOT_W-1:0]  total;
    logic [PIX_W-1:0]         approach_val;
    logic [PIX_W-1:0]         new_val;

    assign b_leave = b_valid_reg && (!out_valid_reg || pix_out.ready);
    assign pop     = !q_stat.empty && (!b_valid_reg || b_leave);

    assign pix_out.valid = out_valid_reg;
    assign pix_out.data  = out_item_reg;

    // The item just ahead writes its entry at the same edge this one reads it,
    // so a matching index takes the written value instead of the memory data.
    always_comb
    begin
        if (!b_task_reg.in_range)
        begin
            acc = '0;
        end
        else if (fwd_hit_reg)
        begin
            acc = fwd_data_reg;
        end
        else
        begin
            acc = rd_data_reg;
        end
    end

    always_comb
    begin
        delta   = $signed({1'b0, b_task_reg.src}) - $signed({1'b0, acc});
        gain    = $signed({1'b0, (delta < 0) ? cfg.fall_gain : cfg.rise_gain});
        product = TOT_W'(delta) * TOT_W'(gain);
        total   = $signed({{(TOT_W - PIX_W - FRAC_W){1'b0}}, acc, {FRAC_W{1'b0}}}) + product;
        if (total > TOTAL_MAX)
        begin
            approach_val = PIX_MAX;
        end
        else if (total < 0)
        begin
            approach_val = '0;
        end
        else
        begin
            approach_val = total[FRAC_W +: PIX_W];
        end
    end

    always_comb
    begin
        case (b_task_reg.op)
            OP_LOAD:     new_val = b_task_reg.bg;
            OP_APPROACH: new_val = approach_val;
            OP_HOLD:     new_val = acc;
            default:     new_val = acc;
        endcase
    end

    always_comb
    begin
        b_valid_next   = pop ? 1'b1 : (b_leave ? 1'b0 : b_valid_reg);
        out_valid_next = b_leave ? 1'b1 : (pix_out.ready ? 1'b0 : out_valid_reg);
        fwd_hit_next   = fwd_hit_reg;
        if (pop)
        begin
            fwd_hit_next = b_leave && b_task_reg.in_range && (b_task_reg.idx == head.idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_task_reg   <= head;
            fwd_data_reg <= new_val;
        end
        if (b_leave)
        begin
            out_item_reg.out_index   <= b_task_reg.idx;
            out_item_reg.out_pixel   <= new_val;
            out_item_reg.was_updated <= (b_task_reg.op == OP_APPROACH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.in_range)
        begin
            rd_data_reg <= frame_mem[head.idx[ADDR_W-1:0]];
        end
        if (b_leave && b_task_reg.in_range)
        begin
            frame_mem[b_task_reg.idx[ADDR_W-1:0]] <= new_val;
        end
    end

endmodule
